// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, skipped while rst is high.
`define DCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define DCS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dcsync_pkg.sv
// Constants and shared types of the distributed clock PI synchronizer.
package dcsync_pkg;

  localparam logic [30:0] NS_PER_SEC    = 31'd1000000000;
  localparam logic [62:0] SYNC_SHIFT_NS = 63'd50000;
  localparam logic [29:0] P_DIVISOR     = 30'd100;
  localparam logic [29:0] I_DIVISOR     = 30'd20;
  localparam logic [29:0] CYCLE_RESET   = 30'd1000000;

  // Iteration counts of the serial divider, one quotient bit per cycle.
  localparam logic [5:0] STEPS_MOD = 6'd63;
  localparam logic [5:0] STEPS_P   = 6'd30;
  localparam logic [5:0] STEPS_I   = 6'd32;

  localparam logic signed [31:0] INTEG_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] INTEG_MIN = 32'sh80000000;

  // Configuration register indexes.
  localparam logic [1:0] REG_CYCLE_TIME = 2'd0;
  localparam logic [1:0] REG_START_SEC  = 2'd1;
  localparam logic [1:0] REG_START_NS   = 2'd2;

  typedef struct packed {
    logic       start;
    logic [5:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic go;
    logic load_sec;
    logic load_ns;
  } dl_cmd_t;

endpackage

// File: rtl/dc_clock_sync_pi_top.sv
// Top level of the distributed clock PI synchronizer.
// Each transfer on the input channel carries one cycle's reference clock time in
// nanoseconds and yields one result: the advanced wake deadline, the wrapped phase
// error and the PI offset applied to the next period. The bit-serial divider first
// takes the remainder of the reference time by the cycle time; sign, wrap and
// integral handling follow, and then the proportional and integral quotients run
// side by side. The input is ready again in the same cycle that the result
// appears in the output register; a result that is still waiting to be taken
// when the next one is done holds that next one back.
// One item is worked on at a time; a finished result waits in the output register
// while the next item is taken.
// Configuration must be written only while the block is idle, which the block does not
// enforce; writing a start register also loads the matching part of the deadline.
module dc_clock_sync_pi_top
  import dcsync_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [62:0]        dc_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [27:0] offset_ns,
  output logic signed [30:0] phase_error_ns,
  output logic [31:0]        wake_seconds,
  output logic [29:0]        wake_nanoseconds
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_SIGN, ST_WRAP, ST_INTEG, ST_QSTART, ST_QWAIT, ST_FIN
  } state_t;

  state_t             state;
  logic [29:0]        period;
  logic               neg;
  logic signed [30:0] err;
  logic signed [31:0] integ;
  logic signed [27:0] applied_off;

  logic               in_xfer;
  logic [62:0]        mag;
  logic signed [31:0] step;
  logic [29:0]        abs_err;
  logic [31:0]        abs_integ;
  logic [27:0]        p_term;
  logic [27:0]        i_term;
  logic [27:0]        off_sum;

  div_ctl_t    ctl_a, ctl_b;
  logic [62:0] dvd_a, dvd_b;
  logic [29:0] dvs_a;
  logic        busy_a, busy_b;
  logic [62:0] quot_a, quot_b;
  logic [29:0] rem_a, rem_b;

  dl_cmd_t     dl_cmd;
  logic        dl_busy;
  logic [31:0] dl_seconds;
  logic [29:0] dl_nanoseconds;

  always_comb begin
    in_ready = state == ST_IDLE;
    in_xfer  = in_valid && in_ready;

    // Distance of the reference time from the sync point; the sign is kept apart.
    if (dc_time >= SYNC_SHIFT_NS) begin
      mag = dc_time - SYNC_SHIFT_NS;
    end else begin
      mag = SYNC_SHIFT_NS - dc_time;
    end

    step      = $signed({2'b0, period}) + 32'(applied_off);
    abs_err   = err[30] ? 30'(-err) : err[29:0];
    abs_integ = integ[31] ? 32'(-integ) : 32'(integ);

    // Quotient A serves the remainder first and the proportional term later.
    ctl_a.start = in_xfer || (state == ST_QSTART);
    ctl_a.steps = (state == ST_QSTART) ? STEPS_P : STEPS_MOD;
    dvd_a       = (state == ST_QSTART) ? {abs_err, 33'd0} : mag;
    dvs_a       = (state == ST_QSTART) ? P_DIVISOR : period;

    ctl_b.start = state == ST_QSTART;
    ctl_b.steps = STEPS_I;
    dvd_b       = {abs_integ, 31'd0};

    // Both quotients truncate toward zero; the offset negates each term.
    p_term  = err[30] ? quot_a[27:0] : -quot_a[27:0];
    i_term  = integ[31] ? quot_b[27:0] : -quot_b[27:0];
    off_sum = p_term + i_term;

    dl_cmd.go       = in_xfer;
    dl_cmd.load_sec = cfg_we && (cfg_index == REG_START_SEC);
    dl_cmd.load_ns  = cfg_we && (cfg_index == REG_START_NS);
  end

  dcsync_serdiv u_div_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_a),
    .dividend (dvd_a),
    .divisor  (dvs_a),
    .busy     (busy_a),
    .quot     (quot_a),
    .rem      (rem_a)
  );

  dcsync_serdiv u_div_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_b),
    .dividend (dvd_b),
    .divisor  (I_DIVISOR),
    .busy     (busy_b),
    .quot     (quot_b),
    .rem      (rem_b)
  );

  dcsync_deadline u_deadline (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dl_cmd),
    .step        (step),
    .cfg_data    (cfg_data),
    .busy        (dl_busy),
    .seconds     (dl_seconds),
    .nanoseconds (dl_nanoseconds)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      period      <= CYCLE_RESET;
      integ       <= '0;
      applied_off <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_CYCLE_TIME)) begin
        period <= cfg_data[29:0];
      end
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            neg   <= dc_time < SYNC_SHIFT_NS;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (!busy_a) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          // A zero cycle time leaves the remainder undefined; the error is then zero.
          if (period == '0) begin
            err <= '0;
          end else if (neg) begin
            err <= -$signed({1'b0, rem_a});
          end else begin
            err <= $signed({1'b0, rem_a});
          end
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          if (err > $signed({2'b0, period[29:1]})) begin
            err <= err - $signed({1'b0, period});
          end
          state <= ST_INTEG;
        end
        ST_INTEG: begin
          if (err > 31'sd0 && integ != INTEG_MAX) begin
            integ <= integ + 32'sd1;
          end else if (err < 31'sd0 && integ != INTEG_MIN) begin
            integ <= integ - 32'sd1;
          end
          state <= ST_QSTART;
        end
        ST_QSTART: begin
          state <= ST_QWAIT;
        end
        ST_QWAIT: begin
          if (!busy_a && !busy_b && !dl_busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            offset_ns        <= $signed(off_sum);
            phase_error_ns   <= err;
            wake_seconds     <= dl_seconds;
            wake_nanoseconds <= dl_nanoseconds;
            applied_off      <= $signed(off_sum);
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dcsync_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, left-aligned dividend.
module dcsync_serdiv
  import dcsync_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctl_t    ctl,
  input  logic [62:0] dividend,
  input  logic [29:0] divisor,
  output logic        busy,
  output logic [62:0] quot,
  output logic [29:0] rem
);

  logic [5:0]  cnt;
  logic [29:0] dvs;
  logic [30:0] trial;
  logic        fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem, quot[62]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= ctl.steps;
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[61:0], fits};
      rem  <= fits ? 30'(trial - {1'b0, dvs}) : trial[29:0];
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/dcsync_deadline.sv
// Wake deadline register pair with a short sequencer that advances and normalizes it.
module dcsync_deadline
  import dcsync_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dl_cmd_t            cmd,
  input  logic signed [31:0] step,
  input  logic [31:0]        cfg_data,
  output logic               busy,
  output logic [31:0]        seconds,
  output logic [29:0]        nanoseconds
);

  typedef enum logic [1:0] {DL_IDLE, DL_ADD, DL_NORM1, DL_NORM2} dl_state_t;

  dl_state_t   state;
  logic [30:0] ns;
  logic [29:0] rem;
  logic [30:0] clamped;

  always_comb begin
    clamped     = step[31] ? '0 : step[30:0];
    busy        = state != DL_IDLE;
    nanoseconds = ns[29:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= DL_IDLE;
      seconds <= '0;
      ns      <= '0;
    end else begin
      case (state)
        DL_IDLE: begin
          if (cmd.go) begin
            // Whole seconds of the step first; the step is below two seconds.
            if (clamped >= NS_PER_SEC) begin
              seconds <= seconds + 32'd1;
              rem     <= 30'(clamped - NS_PER_SEC);
            end else begin
              rem <= clamped[29:0];
            end
            state <= DL_ADD;
          end else begin
            if (cmd.load_sec) begin
              seconds <= cfg_data;
            end
            if (cmd.load_ns) begin
              ns <= {1'b0, cfg_data[29:0]};
            end
          end
        end
        DL_ADD: begin
          ns    <= ns + {1'b0, rem};
          state <= DL_NORM1;
        end
        DL_NORM1, DL_NORM2: begin
          // The sum stays below three seconds, so two folds normalize it.
          if (ns >= NS_PER_SEC) begin
            ns      <= ns - NS_PER_SEC;
            seconds <= seconds + 32'd1;
          end
          state <= (state == DL_NORM1) ? DL_NORM2 : DL_IDLE;
        end
        default: state <= DL_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dcsync_checker.sv
// Port-level checks of the synchronizer, bound to the top level.
`include "assert_macros.svh"

module dcsync_checker
  import dcsync_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [27:0] offset_ns,
  input logic signed [30:0] phase_error_ns,
  input logic [31:0]        wake_seconds,
  input logic [29:0]        wake_nanoseconds
);

  // A result that is not taken keeps its value.
  `DCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(offset_ns) && $stable(wake_seconds), "stalled result changed")

  // The deadline leaves every step normalized.
  `DCS_ASSERT(a_ns_norm, out_valid |-> wake_nanoseconds < 30'd1000000000, "wake nanoseconds not normalized")

  // The wrapped error stays within half of the largest 30-bit cycle above and one cycle below.
  `DCS_ASSERT(a_err_range, out_valid |-> phase_error_ns <= 31'sd536870911 && phase_error_ns >= -31'sd1073741822, "phase error out of range")

  // One item at a time: an input transfer is never directly followed by another.
  `DCS_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // Reset leaves no result pending.
  `DCS_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result pending after reset")

endmodule

bind dc_clock_sync_pi_top dcsync_checker u_dcsync_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for dc_clock_sync_pi_top with its own PI synchronizer predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcsync_pkg::*;

  localparam longint NS_SECOND      = 1_000_000_000;
  localparam longint SYNC_POINT_NS  = 50000;
  localparam longint PROP_GAIN_DIV  = 100;
  localparam longint INTEG_GAIN_DIV = 20;
  localparam logic [1:0]  REG_UNUSED = 2'd3;
  localparam logic [62:0] STAMP_MAX  = '1;
  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_MOSTLY, RX_SPARSE} rx_mode_t;
  typedef enum logic [1:0] {ERR_CENTERED, ERR_POSITIVE, ERR_NEGATIVE} err_mode_t;

  typedef struct {
    logic signed [27:0] offset;
    logic signed [30:0] phase;
    logic [31:0]        sec;
    logic [29:0]        nsec;
  } correction_t;

  class pi_sync_scoreboard;
    correction_t expected_corrections[$];
    int unsigned mismatches;
    int unsigned results_seen;
    logic [29:0] period_ns;
    longint      integ_count;
    longint      last_offset;
    logic [31:0] wake_sec;
    logic [29:0] wake_nsec;

    function new();
      period_ns    = CYCLE_RESET;
      integ_count  = 0;
      last_offset  = 0;
      wake_sec     = '0;
      wake_nsec    = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // A start register write also reloads that half of the wake deadline.
    function void load_register(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        REG_CYCLE_TIME: period_ns = val[29:0];
        REG_START_SEC:  wake_sec  = val;
        REG_START_NS:   wake_nsec = val[29:0];
        default: ;
      endcase
    endfunction

    function void accept_dc_time(input logic [62:0] stamp);
      longint step, nsum, per, err, ref_time, corr;
      correction_t want;
      per      = {34'd0, period_ns};
      ref_time = {1'b0, stamp};
      // The deadline moves by the period plus the previous correction, never backward.
      step = per + last_offset;
      if (step < 0) step = 0;
      wake_sec = 32'(wake_sec + step / NS_SECOND);
      nsum = {34'd0, wake_nsec} + step % NS_SECOND;
      if (nsum >= NS_SECOND) begin
        wake_sec = 32'(wake_sec + nsum / NS_SECOND);
        nsum = nsum % NS_SECOND;
      end
      wake_nsec = nsum[29:0];
      if (per == 0) begin
        err = 0;
      end else begin
        if (ref_time >= SYNC_POINT_NS) err = (ref_time - SYNC_POINT_NS) % per;
        else err = -((SYNC_POINT_NS - ref_time) % per);
        if (err > per / 2) err = err - per;
      end
      if (err > 0 && integ_count < INTEG_MAX) integ_count++;
      if (err < 0 && integ_count > INTEG_MIN) integ_count--;
      corr = -(err / PROP_GAIN_DIV) - (integ_count / INTEG_GAIN_DIV);
      last_offset = corr;
      want.offset = corr[27:0];
      want.phase  = err[30:0];
      want.sec    = wake_sec;
      want.nsec   = wake_nsec;
      expected_corrections.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_corrections.size();
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_correction(input correction_t got);
      correction_t want;
      results_seen++;
      if (expected_corrections.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no input pending", results_seen));
        return;
      end
      want = expected_corrections.pop_front();
      if (got.offset !== want.offset)
        report_mismatch($sformatf("result %0d offset_ns got %0d expected %0d",
                                  results_seen, got.offset, want.offset));
      if (got.phase !== want.phase)
        report_mismatch($sformatf("result %0d phase_error_ns got %0d expected %0d",
                                  results_seen, got.phase, want.phase));
      if (got.sec !== want.sec)
        report_mismatch($sformatf("result %0d wake_seconds got %0d expected %0d",
                                  results_seen, got.sec, want.sec));
      if (got.nsec !== want.nsec)
        report_mismatch($sformatf("result %0d wake_nanoseconds got %0d expected %0d",
                                  results_seen, got.nsec, want.nsec));
    endtask
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [62:0]        dc_time   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [27:0] offset_ns;
  logic signed [30:0] phase_error_ns;
  logic [31:0]        wake_seconds;
  logic [29:0]        wake_nanoseconds;

  pi_sync_scoreboard sb = new();

  dc_clock_sync_pi_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .dc_time          (dc_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .offset_ns        (offset_ns),
    .phase_error_ns   (phase_error_ns),
    .wake_seconds     (wake_seconds),
    .wake_nanoseconds (wake_nanoseconds)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dc_clock_sync_pi_top test failed");
    $finish;
  end

  // Receiver: checks each output transfer and stalls on a pattern of its own.
  int          hold_orders = 0;
  int          hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_seg_left = 0;
  int unsigned rx_pos      = 0;
  rx_mode_t    rx_mode     = RX_ALWAYS;
  logic [15:0] rx_mask     = '1;
  logic        ready_next;
  correction_t rx_got;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rx_got.offset = offset_ns;
      rx_got.phase  = phase_error_ns;
      rx_got.sec    = wake_seconds;
      rx_got.nsec   = wake_nanoseconds;
      sb.check_correction(rx_got);
    end
    if (hold_served != hold_orders) begin
      hold_served = hold_orders;
      hold_left = HOLD_CYCLES;
    end
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(16, 200);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mask = 16'($urandom) | 16'h0001;
    end else begin
      rx_seg_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  ready_next = 1'b1;
        RX_PATTERN: ready_next = rx_mask[rx_pos % 16];
        RX_MOSTLY:  ready_next = ($urandom_range(0, 3) != 0);
        default:    ready_next = ($urandom_range(0, 3) == 0);
      endcase
    end
    rx_pos++;
    out_ready <= ready_next;
  end

  // Valid stays high from one transfer into the next; only a gap or a drain lowers it.
  task automatic send_item(input logic [62:0] stamp);
    in_valid <= 1'b1;
    dc_time  <= stamp;
    do @(posedge clk); while (!in_ready);
    sb.accept_dc_time(stamp);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      dc_time  <= 63'({$urandom, $urandom});
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.load_register(idx, val);
  endtask

  task automatic finish_writes();
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_period_word();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'($urandom_range(2, 999));
      3:       return 32'd1000;
      4:       return 32'd1_000_000_000;
      5:       return 32'h3FFF_FFFF;
      6:       return $urandom;
      7, 8:    return 32'($urandom_range(1_000_000, 1_000_000_000));
      default: return 32'($urandom_range(1000, 1_000_000));
    endcase
  endfunction

  // Mostly timestamps that track the cycle grid with a chosen error trend, plus noise.
  task automatic run_phase(input longint per, input err_mode_t mode, input int unsigned n_items);
    longint      base, cnt, e, span;
    int unsigned burst_left, gap;
    logic [62:0] stamp;
    base = ($urandom_range(0, 7) == 0) ? 0 : longint'({$urandom, $urandom} >> 2);
    span = (per / 16 > 1) ? per / 16 : 1;
    if ($urandom_range(0, 3) == 0 && per > 0) span = per;
    cnt = 0;
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0, 1, 2, 3:    gap = 0;
          4, 5, 6, 7, 8: gap = $urandom_range(1, 8);
          default:       gap = $urandom_range(9, 130);
        endcase
        sender_gap(gap);
      end
      burst_left--;
      if ($urandom_range(0, 3) != 0) begin
        case (mode)
          ERR_POSITIVE: e = longint'($urandom_range(1, 32'(span)));
          ERR_NEGATIVE: e = -longint'($urandom_range(1, 32'(span)));
          default:      e = longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
        stamp = 63'(base + cnt * per + SYNC_POINT_NS + e);
        cnt++;
      end else begin
        case ($urandom_range(0, 3))
          0:       stamp = 63'({$urandom, $urandom});
          1:       stamp = 63'($urandom_range(0, 60000));
          2:       stamp = STAMP_MAX - 63'($urandom_range(0, 1000));
          default: stamp = 63'({$urandom, $urandom}) >> $urandom_range(0, 62);
        endcase
      end
      send_item(stamp);
    end
  endtask

  initial begin : stimulus
    int unsigned sent, phase_no, len;
    logic [31:0] period_word;
    err_mode_t   mode;
    sent = 0;
    phase_no = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: both sides of the sync point, the half-cycle wrap, extremes.
    send_item(63'd0);
    send_item(63'd49999);
    send_item(63'd50000);
    send_item(63'd50001);
    send_item(63'd550000);
    send_item(63'd550001);
    send_item(63'd1049999);
    send_item(STAMP_MAX);
    // Zero cycle time, with the deadline at the top of the seconds range.
    drain_results();
    write_reg(REG_CYCLE_TIME, 32'd0);
    write_reg(REG_START_SEC, 32'hFFFF_FFFF);
    write_reg(REG_START_NS, 32'd999_999_999);
    finish_writes();
    send_item(63'd12345);
    send_item(STAMP_MAX);
    // An unused index is ignored; nanoseconds beyond one second fold into seconds.
    drain_results();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_CYCLE_TIME, 32'hFFFF_FFFF);
    write_reg(REG_START_NS, 32'h3FFF_FFFF);
    finish_writes();
    send_item(63'd0);
    send_item(STAMP_MAX);
    send_item(63'd50000);
    drain_results();
    write_reg(REG_CYCLE_TIME, 32'd1_000_000_000);
    write_reg(REG_START_SEC, 32'hFFFF_FFFF);
    finish_writes();
    send_item(63'd1_000_050_000);
    send_item(63'd500_050_000);
    send_item(63'd500_050_001);
    drain_results();
    write_reg(REG_CYCLE_TIME, 32'd1000);
    write_reg(REG_START_SEC, 32'd0);
    write_reg(REG_START_NS, 32'd0);
    finish_writes();
    send_item(63'd50500);
    send_item(63'd50501);
    send_item(63'd49000);
    drain_results();
    write_reg(REG_CYCLE_TIME, 32'd1);
    finish_writes();
    send_item(63'd777);

    // A tiny period with steady positive error drives the correction below minus one
    // period, so the following phases see the deadline held still.
    while (sent < RANDOM_ITEMS) begin
      case (phase_no)
        0: begin
          period_word = 32'd3;
          mode = ERR_POSITIVE;
          len = 130;
        end
        1: begin
          period_word = 32'd0;
          mode = ERR_CENTERED;
          len = 30;
        end
        default: begin
          period_word = pick_period_word();
          mode = err_mode_t'($urandom_range(0, 2));
          len = $urandom_range(30, 140);
        end
      endcase
      drain_results();
      write_reg(REG_CYCLE_TIME, period_word);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_START_SEC, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_START_NS, ($urandom_range(0, 1) == 0) ?
                                32'($urandom_range(0, 999_999_999)) : $urandom);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
      finish_writes();
      if (phase_no == 2 || $urandom_range(0, 9) == 0) hold_orders <= hold_orders + 1;
      run_phase({34'd0, period_word[29:0]}, mode, len);
      sent += len;
      phase_no++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) $display("dc_clock_sync_pi_top test passed");
    else $display("dc_clock_sync_pi_top test failed");
    $finish;
  end

endmodule
